>>> hdl/lcd_pkg.sv
`timescale 1ns / 1ps

package lcd_pkg;

    localparam int LANE_COUNT  = 3;
    localparam int PATH_POINTS = 50;

    localparam int LANE_W = 2;
    localparam int POS_W  = 21;
    localparam int SPD_W  = 15;
    localparam int PTS_W  = 6;
    localparam int D_W    = 12;
    localparam int VEL_W  = 15;
    localparam int REF_W  = 16;
    localparam int STEP_W = 12;
    localparam int GAP_W  = 16;
    localparam int SPAN_W = 12;
    localparam int ACT_W  = 3;
    localparam int MODE_W = 2;

    // square root unit: 30-bit radicand, 15 result bits, one bit per cycle
    localparam int SQ_W       = 30;
    localparam int ROOT_W     = 15;
    localparam int ITER_W     = 4;
    localparam int ROOT_STEPS = 15;

    // projection: floor(points * speed / PATH_POINTS) by reciprocal multiply
    localparam int PROD_W     = PTS_W + ROOT_W;
    localparam int DIV_SHIFT  = 27;
    localparam int DIV_MULT_W = 28;
    localparam int DIV_MULT   = (2 ** DIV_SHIFT + PATH_POINTS - 1) / PATH_POINTS;
    localparam int DIV_PROD_W = PROD_W + DIV_MULT_W;
    localparam int CS_W       = POS_W + 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_SAFE_GAP      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_CEILING = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_STEP    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BRAKE_STEP    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LANE_SPAN     = 3'd4;

    localparam logic [GAP_W-1:0]  SAFE_GAP_RST      = 16'd5120;
    localparam logic [REF_W-1:0]  SPEED_CEILING_RST = 16'd49500;
    localparam logic [STEP_W-1:0] ACCEL_STEP_RST    = 12'd224;
    localparam logic [STEP_W-1:0] BRAKE_STEP_RST    = 12'd100;
    localparam logic [SPAN_W-1:0] LANE_SPAN_RST     = 12'd1024;
    localparam logic [LANE_W-1:0] LANE_RST          = 2'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_EGO    = 2'd0,
        MODE_CAR    = 2'd1,
        MODE_DECIDE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_EGO,
        OP_CAR,
        OP_DECIDE
    } op_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_ACCEL = 3'd0,
        ACT_HOLD  = 3'd1,
        ACT_LEFT  = 3'd2,
        ACT_RIGHT = 3'd3,
        ACT_BRAKE = 3'd4
    } act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_SCALE,
        ST_DIVIDE,
        ST_FLAGS
    } st_t;

    typedef struct packed {
        op_t                     op;
        logic [POS_W-1:0]        pos;
        logic [SPD_W-1:0]        speed;
        logic [PTS_W-1:0]        pts;
        logic [D_W-1:0]          d;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
    } cmd_t;

    typedef struct packed {
        logic [GAP_W-1:0]  safe_gap;
        logic [REF_W-1:0]  speed_ceiling;
        logic [STEP_W-1:0] accel_step;
        logic [STEP_W-1:0] brake_step;
        logic [SPAN_W-1:0] lane_span;
    } cfg_t;

    typedef struct packed {
        logic empty;
        logic ready;
    } q_stat_t;

    // lane j spans the open interval (j*span, (j+1)*span)
    function automatic logic lane_hit(input logic [D_W-1:0] d, input logic [2:0] j,
                                      input logic [SPAN_W-1:0] span);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = 16'(j) * 16'(span);
        hi = lo + 16'(span);
        return (16'(d) > lo) && (16'(d) < hi);
    endfunction

endpackage

>>> hdl/lcd_item_if.sv
`timescale 1ns / 1ps

interface lcd_item_if;
    import lcd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [POS_W-1:0]        ego_s;
    logic [POS_W-1:0]        end_s;
    logic [SPD_W-1:0]        ego_speed;
    logic [PTS_W-1:0]        points_left;
    logic [D_W-1:0]          car_d;
    logic signed [VEL_W-1:0] car_vx;
    logic signed [VEL_W-1:0] car_vy;
    logic [POS_W-1:0]        car_s;

    modport source (
        output valid, mode, ego_s, end_s, ego_speed, points_left, car_d, car_vx, car_vy,
               car_s,
        input  ready
    );

    modport sink (
        input  valid, mode, ego_s, end_s, ego_speed, points_left, car_d, car_vx, car_vy,
               car_s,
        output ready
    );
endinterface

>>> hdl/lcd_result_if.sv
`timescale 1ns / 1ps

interface lcd_result_if;
    import lcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [LANE_W-1:0] new_lane;
    logic [REF_W-1:0]  ref_speed;
    logic [ACT_W-1:0]  action;
    logic              ahead_close;
    logic              behind_close;
    logic              left_open;
    logic              right_open;

    modport source (
        output valid, new_lane, ref_speed, action, ahead_close, behind_close, left_open,
               right_open,
        input  ready
    );

    modport sink (
        input  valid, new_lane, ref_speed, action, ahead_close, behind_close, left_open,
               right_open,
        output ready
    );
endinterface

>>> hdl/lcd_front.sv
`timescale 1ns / 1ps

module lcd_front (
    input  logic           clk,
    input  logic           rst_n,
    lcd_item_if.sink       item_in,
    input  lcd_pkg::q_stat_t q_stat,
    output logic           q_push,
    output lcd_pkg::cmd_t  q_cmd
);
    import lcd_pkg::*;

    logic cmd_valid_reg;
    logic cmd_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;
    logic keep;

    assign item_in.ready = !cmd_valid_reg || q_stat.ready;
    assign accept        = item_in.valid && item_in.ready;
    assign q_push        = cmd_valid_reg;
    assign q_cmd         = cmd_reg;

    // classify; unused mode is dropped here
    always_comb
    begin
        cmd_next       = cmd_reg;
        keep           = 1'b1;
        cmd_next.pos   = item_in.car_s;
        cmd_next.speed = item_in.ego_speed;
        cmd_next.pts   = item_in.points_left;
        cmd_next.d     = item_in.car_d;
        cmd_next.vx    = item_in.car_vx;
        cmd_next.vy    = item_in.car_vy;
        unique case (item_in.mode)
            MODE_EGO:
            begin
                cmd_next.op  = OP_EGO;
                cmd_next.pos = (item_in.points_left != '0) ? item_in.end_s : item_in.ego_s;
            end
            MODE_CAR:    cmd_next.op = OP_CAR;
            MODE_DECIDE: cmd_next.op = OP_DECIDE;
            default:
            begin
                cmd_next.op = OP_DECIDE;
                keep        = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            cmd_valid_next = keep;
        end
        else if (q_stat.ready)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

>>> hdl/lcd_queue.sv
`timescale 1ns / 1ps

module lcd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lcd_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output lcd_pkg::cmd_t    head,
    output lcd_pkg::q_stat_t stat
);
    import lcd_pkg::*;

    cmd_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;
    logic            push_en;
    logic            pop_en;

    assign stat.empty = (count_reg == '0);
    assign stat.ready = (count_reg != Q_CW'(Q_DEPTH));
    assign push_en    = push && stat.ready;
    assign pop_en     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_en && !pop_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_en && !push_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/lcd_back.sv
`timescale 1ns / 1ps

module lcd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  lcd_pkg::cfg_t    cfg,
    input  lcd_pkg::q_stat_t q_stat,
    input  lcd_pkg::cmd_t    q_head,
    output logic             q_pop,
    lcd_result_if.source     result_out
);
    import lcd_pkg::*;

    st_t state_reg;
    st_t state_next;

    logic [LANE_W-1:0] lane_reg,         lane_next;
    logic [REF_W-1:0]  speed_reg,        speed_next;
    logic [POS_W-1:0]  frame_s_reg,      frame_s_next;
    logic [SPD_W-1:0]  frame_speed_reg,  frame_speed_next;
    logic [PTS_W-1:0]  frame_points_reg, frame_points_next;
    logic              ahead_reg,        ahead_next;
    logic              behind_reg,       behind_next;
    logic              left_ok_reg,      left_ok_next;
    logic              right_ok_reg,     right_ok_next;
    logic              out_valid_reg,    out_valid_next;

    logic [SQ_W-1:0]   rem_reg,   rem_next;
    logic [SQ_W-1:0]   root_reg,  root_next;
    logic [ITER_W-1:0] iter_reg,  iter_next;
    logic [PROD_W-1:0] prod_reg,  prod_next;
    logic [POS_W-1:0]  quot_reg,  quot_next;
    logic [D_W-1:0]    car_d_reg, car_d_next;
    logic [POS_W-1:0]  car_s_reg, car_s_next;

    logic [LANE_W-1:0] o_lane_reg,   o_lane_next;
    logic [REF_W-1:0]  o_speed_reg,  o_speed_next;
    act_t              o_act_reg,    o_act_next;
    logic              o_ahead_reg,  o_ahead_next;
    logic              o_behind_reg, o_behind_next;
    logic              o_left_reg,   o_left_next;
    logic              o_right_reg,  o_right_next;

    logic                  head_ok;
    logic                  lopen;
    logic                  ropen;
    logic [2:0]            lane3;
    logic [SQ_W-1:0]       bit_val;
    logic [SQ_W:0]         trial;
    logic [DIV_PROD_W-1:0] div_prod;
    logic [CS_W-1:0]       cs;
    logic [CS_W-1:0]       fs;
    logic [CS_W-1:0]       gap_ahead;
    logic [CS_W-1:0]       gap_behind;
    logic [CS_W-1:0]       sep;
    logic                  risky;
    logic [REF_W:0]        accel_sum;
    logic [2*VEL_W-1:0]    sq_x;
    logic [2*VEL_W-1:0]    sq_y;

    assign lane3   = 3'(lane_reg);
    assign lopen   = (lane_reg != '0) && left_ok_reg;
    assign ropen   = ((lane3 + 3'd1) < 3'(LANE_COUNT)) && right_ok_reg;
    assign head_ok = !q_stat.empty
                     && ((q_head.op != OP_DECIDE) || !out_valid_reg || result_out.ready);

    assign bit_val = SQ_W'(1) << {iter_reg, 1'b0};
    assign trial   = {1'b0, root_reg} + {1'b0, bit_val};

    assign div_prod = DIV_PROD_W'(prod_reg) * DIV_PROD_W'(DIV_MULT);

    assign sq_x = (2*VEL_W)'(q_head.vx * q_head.vx);
    assign sq_y = (2*VEL_W)'(q_head.vy * q_head.vy);

    assign cs         = CS_W'(car_s_reg) + CS_W'(quot_reg);
    assign fs         = CS_W'(frame_s_reg);
    assign gap_ahead  = cs - fs;
    assign gap_behind = fs - cs;
    assign sep        = (cs > fs) ? gap_ahead : gap_behind;
    assign risky      = (sep < CS_W'(cfg.safe_gap))
                        || (root_reg[ROOT_W-1:0] > frame_speed_reg);

    assign accel_sum = (REF_W+1)'(speed_reg) + (REF_W+1)'(cfg.accel_step);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_ok && (q_head.op == OP_CAR))
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (iter_reg == '0)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:  state_next = ST_DIVIDE;
            ST_DIVIDE: state_next = ST_FLAGS;
            ST_FLAGS:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop             = 1'b0;
        lane_next         = lane_reg;
        speed_next        = speed_reg;
        frame_s_next      = frame_s_reg;
        frame_speed_next  = frame_speed_reg;
        frame_points_next = frame_points_reg;
        ahead_next        = ahead_reg;
        behind_next       = behind_reg;
        left_ok_next      = left_ok_reg;
        right_ok_next     = right_ok_reg;
        out_valid_next    = out_valid_reg && !result_out.ready;
        rem_next          = rem_reg;
        root_next         = root_reg;
        iter_next         = iter_reg;
        prod_next         = prod_reg;
        quot_next         = quot_reg;
        car_d_next        = car_d_reg;
        car_s_next        = car_s_reg;
        o_lane_next       = o_lane_reg;
        o_speed_next      = o_speed_reg;
        o_act_next        = o_act_reg;
        o_ahead_next      = o_ahead_reg;
        o_behind_next     = o_behind_reg;
        o_left_next       = o_left_reg;
        o_right_next      = o_right_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop = head_ok;
                if (head_ok)
                begin
                    unique case (q_head.op)
                        OP_EGO:
                        begin
                            frame_s_next      = q_head.pos;
                            frame_speed_next  = q_head.speed;
                            frame_points_next = q_head.pts;
                            ahead_next        = 1'b0;
                            behind_next       = 1'b0;
                            left_ok_next      = 1'b1;
                            right_ok_next     = 1'b1;
                        end
                        OP_CAR:
                        begin
                            rem_next   = SQ_W'(sq_x) + SQ_W'(sq_y);
                            root_next  = '0;
                            iter_next  = ITER_W'(ROOT_STEPS - 1);
                            car_d_next = q_head.d;
                            car_s_next = q_head.pos;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            o_ahead_next   = ahead_reg;
                            o_behind_next  = behind_reg;
                            o_left_next    = lopen;
                            o_right_next   = ropen;
                            if (ahead_reg)
                            begin
                                if (lopen)
                                begin
                                    lane_next  = lane_reg - 1'b1;
                                    o_act_next = ACT_LEFT;
                                end
                                else if (ropen)
                                begin
                                    lane_next  = lane_reg + 1'b1;
                                    o_act_next = ACT_RIGHT;
                                end
                                else
                                begin
                                    speed_next = (speed_reg > REF_W'(cfg.brake_step))
                                                 ? speed_reg - REF_W'(cfg.brake_step) : '0;
                                    o_act_next = ACT_BRAKE;
                                end
                            end
                            else if (speed_reg < cfg.speed_ceiling)
                            begin
                                speed_next = accel_sum[REF_W] ? '1 : accel_sum[REF_W-1:0];
                                o_act_next = ACT_ACCEL;
                            end
                            else
                            begin
                                o_act_next = ACT_HOLD;
                            end
                            o_lane_next  = lane_next;
                            o_speed_next = speed_next;
                        end
                    endcase
                end
            end
            ST_ROOT:
            begin
                iter_next = iter_reg - 1'b1;
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_next  = rem_reg - trial[SQ_W-1:0];
                    root_next = (root_reg >> 1) + bit_val;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
            end
            ST_SCALE:
            begin
                prod_next = PROD_W'(frame_points_reg) * PROD_W'(root_reg[ROOT_W-1:0]);
            end
            ST_DIVIDE:
            begin
                quot_next = div_prod[DIV_SHIFT +: POS_W];
            end
            ST_FLAGS:
            begin
                if (lane_hit(car_d_reg, lane3, cfg.lane_span))
                begin
                    if (cs > fs)
                    begin
                        if (gap_ahead < CS_W'(cfg.safe_gap))
                        begin
                            ahead_next = 1'b1;
                        end
                    end
                    else if (cs < fs)
                    begin
                        if (gap_behind < CS_W'(cfg.safe_gap))
                        begin
                            behind_next = 1'b1;
                        end
                    end
                end
                if ((lane_reg != '0) && lane_hit(car_d_reg, lane3 - 3'd1, cfg.lane_span)
                    && risky)
                begin
                    left_ok_next = 1'b0;
                end
                if (((lane3 + 3'd1) < 3'(LANE_COUNT))
                    && lane_hit(car_d_reg, lane3 + 3'd1, cfg.lane_span) && risky)
                begin
                    right_ok_next = 1'b0;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            lane_reg         <= LANE_RST;
            speed_reg        <= '0;
            frame_s_reg      <= '0;
            frame_speed_reg  <= '0;
            frame_points_reg <= '0;
            ahead_reg        <= 1'b0;
            behind_reg       <= 1'b0;
            left_ok_reg      <= 1'b1;
            right_ok_reg     <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            lane_reg         <= lane_next;
            speed_reg        <= speed_next;
            frame_s_reg      <= frame_s_next;
            frame_speed_reg  <= frame_speed_next;
            frame_points_reg <= frame_points_next;
            ahead_reg        <= ahead_next;
            behind_reg       <= behind_next;
            left_ok_reg      <= left_ok_next;
            right_ok_reg     <= right_ok_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        iter_reg     <= iter_next;
        prod_reg     <= prod_next;
        quot_reg     <= quot_next;
        car_d_reg    <= car_d_next;
        car_s_reg    <= car_s_next;
        o_lane_reg   <= o_lane_next;
        o_speed_reg  <= o_speed_next;
        o_act_reg    <= o_act_next;
        o_ahead_reg  <= o_ahead_next;
        o_behind_reg <= o_behind_next;
        o_left_reg   <= o_left_next;
        o_right_reg  <= o_right_next;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.new_lane     = o_lane_reg;
    assign result_out.ref_speed    = o_speed_reg;
    assign result_out.action       = o_act_reg;
    assign result_out.ahead_close  = o_ahead_reg;
    assign result_out.behind_close = o_behind_reg;
    assign result_out.left_open    = o_left_reg;
    assign result_out.right_open   = o_right_reg;

endmodule

>>> hdl/lane_change_decider_top.sv
`timescale 1ns / 1ps

// channel      dir   handshake     payload
// item_in      in    valid/ready   mode, ego_s, end_s, ego_speed, points_left,
//                                  car_d, car_vx, car_vy, car_s
// result_out   out   valid/ready   new_lane, ref_speed, action, ahead_close,
//                                  behind_close, left_open, right_open
// apb          in    psel/penable  5 registers at 4*i, pready tied high
//
// Ego and decide items are handled in the back end's idle state; a car item runs
// 15 square-root iterations, then scale, divide by reciprocal, flag update.
// The front end takes an item per cycle into a 4-entry queue while the queue is
// not full, so a burst of items is absorbed while a car is in the root unit.
// Reset restores register defaults and the middle lane; no clearing pass.
// A decide item waits in the queue while an earlier result is not yet taken.

module lane_change_decider_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcd_pkg::ADDR_W-1:0]  paddr,
    input  logic [lcd_pkg::DATA_W-1:0]  pwdata,
    output logic [lcd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    lcd_item_if.sink                    item_in,
    lcd_result_if.source                result_out
);
    import lcd_pkg::*;

    logic [GAP_W-1:0]     safe_gap_reg;
    logic [REF_W-1:0]     speed_ceiling_reg;
    logic [STEP_W-1:0]    accel_step_reg;
    logic [STEP_W-1:0]    brake_step_reg;
    logic [SPAN_W-1:0]    lane_span_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    cfg_t                 cfg;
    cmd_t                 push_cmd;
    cmd_t                 head_cmd;
    q_stat_t              q_stat;
    logic                 push;
    logic                 pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_gap_reg      <= SAFE_GAP_RST;
            speed_ceiling_reg <= SPEED_CEILING_RST;
            accel_step_reg    <= ACCEL_STEP_RST;
            brake_step_reg    <= BRAKE_STEP_RST;
            lane_span_reg     <= LANE_SPAN_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SAFE_GAP:      safe_gap_reg      <= pwdata[GAP_W-1:0];
                REG_SPEED_CEILING: speed_ceiling_reg <= pwdata[REF_W-1:0];
                REG_ACCEL_STEP:    accel_step_reg    <= pwdata[STEP_W-1:0];
                REG_BRAKE_STEP:    brake_step_reg    <= pwdata[STEP_W-1:0];
                REG_LANE_SPAN:     lane_span_reg     <= pwdata[SPAN_W-1:0];
                default:           safe_gap_reg      <= safe_gap_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SAFE_GAP:      prdata = DATA_W'(safe_gap_reg);
            REG_SPEED_CEILING: prdata = DATA_W'(speed_ceiling_reg);
            REG_ACCEL_STEP:    prdata = DATA_W'(accel_step_reg);
            REG_BRAKE_STEP:    prdata = DATA_W'(brake_step_reg);
            REG_LANE_SPAN:     prdata = DATA_W'(lane_span_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.safe_gap      = safe_gap_reg;
    assign cfg.speed_ceiling = speed_ceiling_reg;
    assign cfg.accel_step    = accel_step_reg;
    assign cfg.brake_step    = brake_step_reg;
    assign cfg.lane_span     = lane_span_reg;

    lcd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_in),
        .q_stat  (q_stat),
        .q_push  (push),
        .q_cmd   (push_cmd)
    );

    lcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .stat     (q_stat)
    );

    lcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_stat     (q_stat),
        .q_head     (head_cmd),
        .q_pop      (pop),
        .result_out (result_out)
    );

endmodule

>>> hdl/lcd_checker.sv
`timescale 1ns / 1ps

module lcd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [lcd_pkg::ADDR_W-1:0]  paddr,
    input logic [lcd_pkg::DATA_W-1:0]  pwdata,
    input logic [lcd_pkg::DATA_W-1:0]  prdata,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [lcd_pkg::LANE_W-1:0]  res_lane,
    input logic [lcd_pkg::REF_W-1:0]   res_speed,
    input logic [lcd_pkg::ACT_W-1:0]   res_action,
    input logic                        res_ahead,
    input logic                        res_behind,
    input logic                        res_left,
    input logic                        res_right
);
    import lcd_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid
        && $stable({res_lane, res_speed, res_action, res_ahead, res_behind, res_left,
                    res_right}))
        else $error("result changed while stalled");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ({1'b0, res_lane} < 3'(LANE_COUNT)) && (res_action <= ACT_BRAKE))
        else $error("lane or action out of range");

    a_ahead_action: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_ahead == ((res_action == ACT_LEFT) || (res_action == ACT_RIGHT)
                                     || (res_action == ACT_BRAKE))))
        else $error("action disagrees with ahead flag");

    a_move_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_action != ACT_LEFT) || res_left)
                   && ((res_action != ACT_RIGHT) || (res_right && !res_left))
                   && ((res_action != ACT_BRAKE) || (!res_left && !res_right)))
        else $error("lane move order violated");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr == '0))
        ##1 (psel && !pwrite && (paddr == '0))
        |-> (prdata == DATA_W'($past(pwdata[GAP_W-1:0]))))
        else $error("safe gap readback mismatch");

endmodule

bind lane_change_decider_top lcd_checker u_lcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .res_valid  (result_out.valid),
    .res_ready  (result_out.ready),
    .res_lane   (result_out.new_lane),
    .res_speed  (result_out.ref_speed),
    .res_action (result_out.action),
    .res_ahead  (result_out.ahead_close),
    .res_behind (result_out.behind_close),
    .res_left   (result_out.left_open),
    .res_right  (result_out.right_open)
);
